/* hw/rtl/paof_pkg.sv */
package paof_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned FADE_W     = 16;
  localparam int unsigned IDLE_W     = 32;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PRES_W     = 2;
  localparam int unsigned PHASE_W    = 2;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [DIST_W-1:0] NEAR_RST = DIST_W'(1000);
  localparam logic [DIST_W-1:0] FAR_RST  = DIST_W'(3000);
  localparam logic [IDLE_W-1:0] IDLE_RST = IDLE_W'(30000);
  localparam logic [FADE_W-1:0] FADE_RST = FADE_W'(2000);

  typedef enum logic [CMD_W-1:0] {
    CMD_DIST = 2'd0,
    CMD_ACT  = 2'd1,
    CMD_TIME = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR = 2'd0,
    CFG_FAR  = 2'd1,
    CFG_IDLE = 2'd2,
    CFG_FADE = 2'd3
  } cfg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_FADING = 2'd2,
    PH_OFF    = 2'd3
  } ph_e;

  typedef enum logic [PRES_W-1:0] {
    PR_UNKNOWN = 2'd0,
    PR_NEAR    = 2'd1,
    PR_FAR     = 2'd2
  } pr_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_DIV  = 4'b1000
  } st_e;

  typedef struct packed {
    logic              status;
    logic              bright_wr;
    logic [LVL_W-1:0]  bright_val;
    logic              turn_off;
    pr_e               presence;
    ph_e               phase;
  } res_t;

endpackage

/* hw/rtl/paof_if.sv */
interface paof_in_if;
  logic                          valid;
  logic                          ready;
  logic [paof_pkg::CMD_W-1:0]    cmd;
  logic [paof_pkg::DIST_W-1:0]   distance;
  logic [paof_pkg::NOW_W-1:0]    now_ms;
  logic [paof_pkg::LVL_W-1:0]    current_brightness;
  logic                          controller_ready;

  modport source (
    output valid, cmd, distance, now_ms, current_brightness, controller_ready,
    input  ready
  );
  modport sink (
    input  valid, cmd, distance, now_ms, current_brightness, controller_ready,
    output ready
  );
endinterface

interface paof_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          brightness_write;
  logic [paof_pkg::LVL_W-1:0]    brightness_value;
  logic                          turn_off;
  logic [paof_pkg::PRES_W-1:0]   presence;
  logic [paof_pkg::PHASE_W-1:0]  timer_phase;

  modport source (
    output valid, status, brightness_write, brightness_value, turn_off, presence,
           timer_phase,
    input  ready
  );
  modport sink (
    input  valid, status, brightness_write, brightness_value, turn_off, presence,
           timer_phase,
    output ready
  );
endinterface

/* hw/rtl/paof_div.sv */
module paof_div #(
  parameter int unsigned QW = paof_pkg::LVL_W,
  parameter int unsigned DW = paof_pkg::FADE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QW-1:0]    quo_o
);

  localparam int unsigned CNT_W = (QW > 1) ? $clog2(QW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  // The numerator is known to be below den * 2^QW, so the upper part
  // starts out already reduced and QW restoring steps give the quotient.
  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    lo_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DW:0]      shifted, trial;
  logic             ge;

  assign shifted = {rem_q, lo_q[QW-1]};
  assign ge      = shifted >= {1'b0, den_i};
  assign trial   = shifted - {1'b0, den_i};
  assign rem_d   = ge ? trial[DW-1:0] : shifted[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QW+DW-1:QW];
      lo_q  <= num_i[QW-1:0];
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* hw/rtl/presence_auto_off_fader.sv */
// Presence classifier and auto-off fader for an LED controller.
// Events arrive on the in_i channel (valid/ready); each event yields exactly
// one result on the out_o channel. A distance sample updates the near/far
// class, an activity trigger or a change to near arms the auto-off timer,
// and a time update advances the timeout and the linear fade.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while the block is idle, which the block
// does not enforce; they take effect at the next event. Most events produce
// their result in the cycle after the transfer. A time update in the middle
// of a fade computes the level with one multiply and a serial divider that
// retires one quotient bit per cycle, passing through the multiply, load and
// divide states before its result is registered. The divider runs eight steps.
// One event is worked on at a time; a new event is taken once the result
// register is empty or is being emptied in the same cycle.
// Reset clears the phase to idle, the presence to unknown, the time stamps
// and fade level to zero and loads the default register values.
// A stalled receiver holds the result; no further event is taken meanwhile.
module presence_auto_off_fader #(
  parameter int unsigned TIME_BITS = paof_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  paof_in_if.sink                          in_i,
  paof_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [paof_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [paof_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned CW = (TB > paof_pkg::NOW_W) ? TB : paof_pkg::NOW_W;
  localparam int unsigned LW = paof_pkg::LVL_W;
  localparam int unsigned FW = paof_pkg::FADE_W;

  logic [paof_pkg::DIST_W-1:0] near_q, far_q;
  logic [paof_pkg::IDLE_W-1:0] idle_q;
  logic [FW-1:0]               fade_q;

  paof_pkg::ph_e  phase_q, phase_d;
  paof_pkg::pr_e  pres_q, pres_d, pres_new;
  logic [TB-1:0]  act_q, act_d, fst_q, fst_d;
  logic [LW-1:0]  fsl_q, fsl_d;
  paof_pkg::st_e  st_q;

  logic [FW-1:0]    diff_q;
  logic [LW-1:0]    cur_q;
  logic [LW+FW-1:0] prod_q;

  logic            out_valid_q;
  paof_pkg::res_t  res_q, res_ev;

  logic            accept, go_fade, res_load;
  logic [CW-1:0]   now_ext;
  logic [TB-1:0]   now_tb, el_act, el_fade;
  logic            act_to, fade_to;
  logic            div_done;
  logic [LW-1:0]   quo;

  assign in_i.ready = (st_q == paof_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign now_ext = CW'(in_i.now_ms);
  assign now_tb  = now_ext[TB-1:0];
  assign el_act  = now_tb - act_q;
  assign el_fade = now_tb - fst_q;
  assign act_to  = CW'(el_act) >= CW'(idle_q);
  assign fade_to = CW'(el_fade) >= CW'(fade_q);

  // A new result is loaded either straight from an event or at the end of a division.
  assign res_load = (accept && !go_fade) || (st_q == paof_pkg::ST_DIV && div_done);

  always_comb begin
    phase_d  = phase_q;
    pres_d   = pres_q;
    pres_new = pres_q;
    act_d    = act_q;
    fst_d    = fst_q;
    fsl_d    = fsl_q;
    go_fade  = 1'b0;
    res_ev   = '0;
    if (!in_i.controller_ready) begin
      res_ev.status = 1'b1;
    end else begin
      case (paof_pkg::cmd_e'(in_i.cmd))
        paof_pkg::CMD_DIST: begin
          // Near is tested first, so crossed thresholds favor near.
          if (in_i.distance < near_q) begin
            pres_new = paof_pkg::PR_NEAR;
          end else if (in_i.distance > far_q) begin
            pres_new = paof_pkg::PR_FAR;
          end
          if (pres_new != pres_q) begin
            pres_d = pres_new;
            if (pres_new == paof_pkg::PR_NEAR) begin
              act_d   = now_tb;
              phase_d = paof_pkg::PH_ACTIVE;
            end
          end
        end
        paof_pkg::CMD_ACT: begin
          act_d   = now_tb;
          phase_d = paof_pkg::PH_ACTIVE;
        end
        paof_pkg::CMD_TIME: begin
          if (phase_q == paof_pkg::PH_ACTIVE) begin
            if (act_to) begin
              phase_d = paof_pkg::PH_FADING;
              fst_d   = now_tb;
              fsl_d   = in_i.current_brightness;
            end
          end else if (phase_q == paof_pkg::PH_FADING) begin
            if (fade_to) begin
              res_ev.turn_off = 1'b1;
              phase_d         = paof_pkg::PH_OFF;
            end else begin
              go_fade = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_ev.presence = pres_d;
    res_ev.phase    = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= paof_pkg::NEAR_RST;
      far_q  <= paof_pkg::FAR_RST;
      idle_q <= paof_pkg::IDLE_RST;
      fade_q <= paof_pkg::FADE_RST;
    end else if (cfg_we_i) begin
      case (paof_pkg::cfg_idx_e'(cfg_idx_i))
        paof_pkg::CFG_NEAR: near_q <= cfg_data_i[paof_pkg::DIST_W-1:0];
        paof_pkg::CFG_FAR:  far_q  <= cfg_data_i[paof_pkg::DIST_W-1:0];
        paof_pkg::CFG_IDLE: idle_q <= cfg_data_i[paof_pkg::IDLE_W-1:0];
        paof_pkg::CFG_FADE: fade_q <= cfg_data_i[FW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= paof_pkg::PH_IDLE;
      pres_q      <= paof_pkg::PR_UNKNOWN;
      act_q       <= '0;
      fst_q       <= '0;
      fsl_q       <= '0;
      st_q        <= paof_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        paof_pkg::ST_IDLE: begin
          if (accept) begin
            phase_q <= phase_d;
            pres_q  <= pres_d;
            act_q   <= act_d;
            fst_q   <= fst_d;
            fsl_q   <= fsl_d;
            if (go_fade) begin
              st_q <= paof_pkg::ST_MUL;
            end
          end
        end
        paof_pkg::ST_MUL:  st_q <= paof_pkg::ST_LOAD;
        paof_pkg::ST_LOAD: st_q <= paof_pkg::ST_DIV;
        paof_pkg::ST_DIV: begin
          if (div_done) begin
            st_q <= paof_pkg::ST_IDLE;
          end
        end
        default: st_q <= paof_pkg::ST_IDLE;
      endcase
    end
  end

  // Fade operands and the result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= res_ev;
      // Below the fade length the elapsed time fits the fade width.
      diff_q <= fade_q - el_fade[FW-1:0];
      cur_q  <= in_i.current_brightness;
    end
    if (st_q == paof_pkg::ST_MUL) begin
      prod_q <= (LW+FW)'(fsl_q) * (LW+FW)'(diff_q);
    end
    if (st_q == paof_pkg::ST_DIV && div_done) begin
      res_q.status     <= 1'b0;
      res_q.turn_off   <= 1'b0;
      res_q.bright_wr  <= (quo != cur_q);
      res_q.bright_val <= (quo != cur_q) ? quo : '0;
      res_q.presence   <= pres_q;
      res_q.phase      <= phase_q;
    end
  end

  paof_div #(
    .QW (LW),
    .DW (FW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == paof_pkg::ST_LOAD),
    .num_i   (prod_q),
    .den_i   (fade_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = res_q.status;
  assign out_o.brightness_write = res_q.bright_wr;
  assign out_o.brightness_value = res_q.bright_val;
  assign out_o.turn_off         = res_q.turn_off;
  assign out_o.presence         = res_q.presence;
  assign out_o.timer_phase      = res_q.phase;

endmodule

/* tb/sv/tb_presence_auto_off_fader.sv */
`timescale 1ns / 1ps

module tb_presence_auto_off_fader;

  // The cmd field has one code that the block ignores.
  localparam logic [paof_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PRINT_CAP = 200;

  typedef struct packed {
    logic [paof_pkg::CMD_W-1:0]  cmd;
    logic [paof_pkg::DIST_W-1:0] distance;
    logic [paof_pkg::NOW_W-1:0]  now;
    logic [paof_pkg::LVL_W-1:0]  cur;
    logic                        ctrl_rdy;
  } fader_event_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [paof_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [paof_pkg::CFG_W-1:0] cfg_data_i;

  paof_in_if in_if ();
  paof_out_if out_if ();

  presence_auto_off_fader dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register copies and fader state as the block should hold them.
  logic [paof_pkg::DIST_W-1:0] near_thr;
  logic [paof_pkg::DIST_W-1:0] far_thr;
  logic [paof_pkg::IDLE_W-1:0] idle_ms;
  logic [paof_pkg::FADE_W-1:0] fade_len;
  paof_pkg::ph_e phase_st;
  paof_pkg::pr_e pres_cls;
  logic [paof_pkg::NOW_W-1:0] act_stamp;
  logic [paof_pkg::NOW_W-1:0] fade_stamp;
  logic [paof_pkg::LVL_W-1:0] fade_lvl;

  fader_event_t pending_events[$];
  paof_pkg::res_t fader_results_q[$];
  fader_event_t drv_ev;
  bit ev_loaded;
  bit src_idles;
  bit sink_idles;
  int unsigned src_wait;
  int unsigned sink_wait;
  int unsigned live_n;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  logic [paof_pkg::NOW_W-1:0] tick;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic paof_pkg::res_t predict_fader_result(fader_event_t ev);
    paof_pkg::res_t r;
    paof_pkg::pr_e cls;
    logic [paof_pkg::NOW_W-1:0] el;
    logic [23:0] scaled;
    r = '0;
    if (!ev.ctrl_rdy) begin
      r.status = 1'b1;
    end else begin
      case (ev.cmd)
        paof_pkg::CMD_DIST: begin
          cls = pres_cls;
          // The near test comes first, so it wins when the thresholds cross.
          if (ev.distance < near_thr) begin
            cls = paof_pkg::PR_NEAR;
          end else if (ev.distance > far_thr) begin
            cls = paof_pkg::PR_FAR;
          end
          if (cls != pres_cls) begin
            pres_cls = cls;
            if (cls == paof_pkg::PR_NEAR) begin
              act_stamp = ev.now;
              phase_st = paof_pkg::PH_ACTIVE;
            end
          end
        end
        paof_pkg::CMD_ACT: begin
          act_stamp = ev.now;
          phase_st = paof_pkg::PH_ACTIVE;
        end
        paof_pkg::CMD_TIME: begin
          if (phase_st == paof_pkg::PH_ACTIVE) begin
            el = ev.now - act_stamp;
            if (el >= idle_ms) begin
              phase_st = paof_pkg::PH_FADING;
              fade_stamp = ev.now;
              fade_lvl = ev.cur;
            end
          end else if (phase_st == paof_pkg::PH_FADING) begin
            el = ev.now - fade_stamp;
            if (el >= {16'd0, fade_len}) begin
              r.turn_off = 1'b1;
              phase_st = paof_pkg::PH_OFF;
            end else begin
              scaled = fade_lvl * (fade_len - el[paof_pkg::FADE_W-1:0]);
              scaled = scaled / fade_len;
              if (scaled[paof_pkg::LVL_W-1:0] != ev.cur) begin
                r.bright_wr = 1'b1;
                r.bright_val = scaled[paof_pkg::LVL_W-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    r.presence = pres_cls;
    r.phase = phase_st;
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit on);
    return on ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic flag_error(string msg);
    // Printing stops at the cap so that a broken block cannot flood the log; counting goes on.
    if (mismatches < PRINT_CAP) begin
      $display("tb: mismatch @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Source side: one event at a time from the pending queue.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      ev_loaded = 1'b0;
      src_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        fader_results_q.push_back(predict_fader_result(drv_ev));
        ev_loaded = 1'b0;
        src_wait = draw_wait(src_idles);
      end
      if (!ev_loaded) begin
        if (src_wait > 0) begin
          src_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          drv_ev = pending_events.pop_front();
          ev_loaded = 1'b1;
          in_if.cmd <= drv_ev.cmd;
          in_if.distance <= drv_ev.distance;
          in_if.now_ms <= drv_ev.now;
          in_if.current_brightness <= drv_ev.cur;
          in_if.controller_ready <= drv_ev.ctrl_rdy;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: every transfer is checked against the oldest expected result.
  always @(posedge clk_i) begin
    paof_pkg::res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (fader_results_q.size() == 0) begin
          flag_error("result with nothing expected");
        end else begin
          want = fader_results_q.pop_front();
          check_field("status", 8'(out_if.status), 8'(want.status));
          check_field("brightness_write", 8'(out_if.brightness_write),
                      8'(want.bright_wr));
          check_field("brightness_value", out_if.brightness_value, want.bright_val);
          check_field("turn_off", 8'(out_if.turn_off), 8'(want.turn_off));
          check_field("presence", 8'(out_if.presence), 8'(want.presence));
          check_field("timer_phase", 8'(out_if.timer_phase), 8'(want.phase));
        end
        sink_wait = draw_wait(sink_idles);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      out_if.ready <= (sink_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(paof_pkg::cfg_idx_e idx, logic [paof_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      paof_pkg::CFG_NEAR: near_thr = val[paof_pkg::DIST_W-1:0];
      paof_pkg::CFG_FAR:  far_thr = val[paof_pkg::DIST_W-1:0];
      paof_pkg::CFG_IDLE: idle_ms = val[paof_pkg::IDLE_W-1:0];
      paof_pkg::CFG_FADE: fade_len = val[paof_pkg::FADE_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_regs(logic [15:0] nr, logic [15:0] fr, logic [31:0] il, logic [15:0] fd);
    write_reg(paof_pkg::CFG_NEAR, {16'd0, nr});
    write_reg(paof_pkg::CFG_FAR, {16'd0, fr});
    write_reg(paof_pkg::CFG_IDLE, il);
    write_reg(paof_pkg::CFG_FADE, {16'd0, fd});
  endtask

  task automatic queue_event(logic [paof_pkg::CMD_W-1:0] cmd,
                             logic [paof_pkg::DIST_W-1:0] distance,
                             logic [paof_pkg::NOW_W-1:0] now,
                             logic [paof_pkg::LVL_W-1:0] cur, logic rdy);
    fader_event_t ev;
    ev.cmd = cmd;
    ev.distance = distance;
    ev.now = now;
    ev.cur = cur;
    ev.ctrl_rdy = rdy;
    pending_events.push_back(ev);
    if (rdy && cmd != CMD_NONE) begin
      live_n++;
    end
  endtask

  function automatic logic [paof_pkg::LVL_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [paof_pkg::DIST_W-1:0] boundary_dist();
    case ($urandom_range(0, 7))
      0: return near_thr - 16'd1;
      1: return near_thr;
      2: return far_thr;
      3: return far_thr + 16'd1;
      4: return 16'd0;
      5: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stray events: controller not ready, the unused code, samples near the
  // thresholds and time updates that jump anywhere.
  task automatic maybe_noise();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      queue_event(2'($urandom_range(0, 3)), 16'($urandom), $urandom, rand_level(), 1'b0);
    end else if (pick < 8) begin
      queue_event(CMD_NONE, 16'($urandom), $urandom, rand_level(), 1'b1);
    end else if (pick < 18) begin
      queue_event(paof_pkg::CMD_DIST, boundary_dist(), tick, rand_level(), 1'b1);
    end else if (pick < 20) begin
      queue_event(paof_pkg::CMD_TIME, 16'($urandom), $urandom, rand_level(), 1'b1);
    end
  endtask

  // One pass through the timer: arm, wait out the timeout, fade and, most of the time, switch off.
  task automatic queue_session();
    logic [paof_pkg::NOW_W-1:0] act_t;
    logic [paof_pkg::NOW_W-1:0] start_t;
    logic [paof_pkg::NOW_W-1:0] el;
    logic [paof_pkg::LVL_W-1:0] lvl0;
    logic [paof_pkg::LVL_W-1:0] cur;
    logic [23:0] lvl;
    int unsigned n;
    tick += $urandom_range(0, 100);
    if ($urandom_range(0, 9) < 7) begin
      queue_event(paof_pkg::CMD_ACT, 16'($urandom), tick, rand_level(), 1'b1);
    end else begin
      queue_event(paof_pkg::CMD_DIST, far_thr + 16'd1, tick, rand_level(), 1'b1);
      queue_event(paof_pkg::CMD_DIST,
                  (near_thr == 0) ? 16'd0 : 16'($urandom_range(0, near_thr - 1)),
                  tick, rand_level(), 1'b1);
    end
    act_t = tick;
    maybe_noise();
    n = $urandom_range(0, 2);
    repeat (n) begin
      tick += $urandom_range(0, idle_ms / 3);
      queue_event(paof_pkg::CMD_TIME, 16'($urandom), tick, rand_level(), 1'b1);
      maybe_noise();
    end
    tick = act_t + idle_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0);
    lvl0 = rand_level();
    queue_event(paof_pkg::CMD_TIME, 16'($urandom), tick, lvl0, 1'b1);
    start_t = tick;
    n = $urandom_range(1, 8);
    repeat (n) begin
      maybe_noise();
      tick += $urandom_range(0, fade_len / 4 + 1);
      el = tick - start_t;
      cur = rand_level();
      // Now and then the controller already shows the faded level.
      if (el < fade_len && $urandom_range(0, 2) == 0) begin
        lvl = lvl0 * (fade_len - el[paof_pkg::FADE_W-1:0]);
        lvl = lvl / fade_len;
        cur = lvl[paof_pkg::LVL_W-1:0];
      end
      queue_event(paof_pkg::CMD_TIME, 16'($urandom), tick, cur, 1'b1);
    end
    if ($urandom_range(0, 3) != 0) begin
      tick = start_t + fade_len + $urandom_range(0, 3);
      queue_event(paof_pkg::CMD_TIME, 16'($urandom), tick, rand_level(), 1'b1);
    end
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned goal;
    goal = live_n + n;
    while (live_n < goal) begin
      queue_session();
    end
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || ev_loaded || fader_results_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    logic [15:0] nr;
    logic [15:0] fr;
    logic [31:0] il;
    logic [15:0] fd;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = paof_pkg::CFG_NEAR;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.cmd = paof_pkg::CMD_DIST;
    in_if.distance = '0;
    in_if.now_ms = '0;
    in_if.current_brightness = '0;
    in_if.controller_ready = 1'b0;
    out_if.ready = 1'b0;
    near_thr = paof_pkg::NEAR_RST;
    far_thr = paof_pkg::FAR_RST;
    idle_ms = paof_pkg::IDLE_RST;
    fade_len = paof_pkg::FADE_RST;
    phase_st = paof_pkg::PH_IDLE;
    pres_cls = paof_pkg::PR_UNKNOWN;
    act_stamp = '0;
    fade_stamp = '0;
    fade_lvl = '0;
    mismatches = 0;
    live_n = 0;
    src_idles = 1'b0;
    sink_idles = 1'b0;
    tick = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events at the reset register values, back to back.
    queue_event(paof_pkg::CMD_ACT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    queue_event(CMD_NONE, 16'd0, 32'd0, 8'd0, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd100, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'd0, 32'd200, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'd999, 32'd300, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'd1000, 32'd400, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'd3000, 32'd500, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'd3001, 32'd600, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'hFFFF, 32'd700, 8'd10, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd30199, 8'hFF, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd30200, 8'hFF, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd30201, 8'd9, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd31200, 8'd127, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd32199, 8'd200, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd32200, 8'd200, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'd40000, 8'd200, 1'b1);
    queue_event(paof_pkg::CMD_DIST, 16'd500, 32'd41000, 8'd200, 1'b0);
    queue_event(paof_pkg::CMD_DIST, 16'd999, 32'hFFFF_F000, 8'd200, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'hFFFF_F000 + 32'd30000, 8'd200, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'hFFFF_F000 + 32'd30500, 8'd0, 1'b1);
    queue_event(paof_pkg::CMD_ACT, 16'd0, 32'd50000, 8'd0, 1'b1);
    queue_event(paof_pkg::CMD_TIME, 16'd0, 32'hFFFF_FFFF, 8'd0, 1'b0);
    queue_event(CMD_NONE, 16'hFFFF, 32'd0, 8'd0, 1'b0);
    queue_event(paof_pkg::CMD_DIST, 16'd3001, 32'd50100, 8'd0, 1'b1);
    drain();

    src_idles = 1'b1;
    sink_idles = 1'b1;
    set_regs(16'd0, 16'hFFFF, 32'd0, 16'd1);
    queue_random(50);
    drain();
    set_regs(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
    queue_random(50);
    drain();
    // With a zero fade length the first update while fading switches off.
    set_regs(16'd1000, 16'd3000, 32'd50, 16'd0);
    queue_random(50);
    drain();

    repeat (9) begin
      nr = 16'($urandom_range(0, 4000));
      fr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, nr))
                                       : 16'(nr + $urandom_range(0, 4000));
      case ($urandom_range(0, 3))
        0: il = $urandom_range(0, 20);
        1, 2: il = $urandom_range(0, 40000);
        default: il = $urandom;
      endcase
      fd = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4000));
      src_idles = ($urandom_range(0, 3) != 0);
      sink_idles = ($urandom_range(0, 3) != 0);
      set_regs(nr, fr, il, fd);
      queue_random(140);
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
